// File: hw/rtl/mtem_pkg.sv
// Shared types and constants for the multi-timer expiry manager.
// No dependencies; every other file of the block imports this package.
package mtem_pkg;

    localparam int ACTION_W = 2;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 32;
    localparam int STATUS_W = 2;

    // Stream widths: fields packed from bit 0 and padded to whole bytes.
    localparam int S_TDATA_W = ((ID_W + PERIOD_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + STATUS_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted input item
        logic do_cmd;      // execute start/stop/unknown and load its status result
        logic walk_start;  // begin a tick walk: slot 0 is read
        logic walk_step;   // retire the current slot of the walk
        logic flush_emit;  // send the held expiry as the final result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic expire;
        logic idx_last;
        logic pend_valid;
    } t_dp_stat;

endpackage

// File: hw/rtl/mtem_datapath.sv
// Datapath of the timer manager: input and config registers, slot memory,
// running flags, walk index, held expiry and the output payload register.
// Depends on mtem_pkg.
module mtem_datapath import mtem_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [S_TDATA_W-1:0]  i_in_data,
    input  logic [ACTION_W-1:0]   i_in_action,
    input  logic                  i_cfg_wr_en,
    input  logic [PERIOD_W-1:0]   i_cfg_wr_data,
    output logic                  o_out_kind,
    output logic [ID_W-1:0]       o_out_id,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic                  o_out_last
);

    localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WORD_W  = 2 * TICK_WIDTH + 1;
    localparam int RANGE_W = ID_W + 3;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

    logic [ACTION_W-1:0]   r_action;
    logic [ID_W-1:0]       r_id;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_periodic;
    logic [PERIOD_W-1:0]   r_max_period;

    // Slot word: {periodic, reload period, remaining ticks}.
    logic [WORD_W-1:0]     r_mem [NUM_TIMERS];
    logic [WORD_W-1:0]     r_rdata;
    logic [NUM_TIMERS-1:0] r_running;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_pend_valid;
    logic [SLOT_W-1:0]     r_pend_id;

    logic                  r_out_kind;
    logic [ID_W-1:0]       r_out_id;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_last;

    logic [SLOT_W-1:0]     cmd_slot;
    logic                  id_in_range;
    logic                  period_ok;
    logic                  cmd_running;
    logic [STATUS_W-1:0]   cmd_status;
    logic [TICK_WIDTH-1:0] start_ticks;
    logic [WORD_W-1:0]     start_word;
    logic [TICK_WIDTH-1:0] slot_rem;
    logic [TICK_WIDTH-1:0] slot_reload;
    logic                  slot_per;
    logic                  slot_running;
    logic                  expire;
    logic [WORD_W-1:0]     step_word;
    logic                  start_wr;
    logic                  stop_clr;
    logic                  step_wr;
    logic                  idx_last;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  emit_step;

    assign cmd_slot    = SLOT_W'(r_id);
    assign id_in_range = RANGE_W'(r_id) < RANGE_W'(NUM_TIMERS);
    assign cmd_running = r_running[cmd_slot];
    // A period must also fit in the countdown width.
    assign period_ok   = (r_period != '0) && (r_period <= r_max_period)
                         && ((r_period >> TICK_WIDTH) == '0);
    assign start_ticks = TICK_WIDTH'(r_period);
    assign start_word  = {r_periodic, start_ticks, start_ticks};

    always_comb begin
        cmd_status = ST_INVALID;
        case (r_action)
            ACT_START: begin
                if (!id_in_range || !period_ok) begin
                    cmd_status = ST_INVALID;
                end else if (cmd_running) begin
                    cmd_status = ST_BUSY;
                end else begin
                    cmd_status = ST_OK;
                end
            end
            ACT_STOP: begin
                if (!id_in_range) begin
                    cmd_status = ST_INVALID;
                end else if (!cmd_running) begin
                    cmd_status = ST_BUSY;
                end else begin
                    cmd_status = ST_OK;
                end
            end
            default: cmd_status = ST_INVALID;
        endcase
    end

    assign slot_rem     = r_rdata[TICK_WIDTH-1:0];
    assign slot_reload  = r_rdata[2*TICK_WIDTH-1:TICK_WIDTH];
    assign slot_per     = r_rdata[WORD_W-1];
    assign slot_running = r_running[r_idx];
    assign expire       = slot_running && (slot_rem <= TICK_WIDTH'(1));
    assign step_word    = expire ? {slot_per, slot_reload, slot_reload}
                                 : {slot_per, slot_reload, slot_rem - TICK_WIDTH'(1)};

    assign start_wr  = i_cmd.do_cmd && (r_action == ACT_START) && (cmd_status == ST_OK);
    assign stop_clr  = i_cmd.do_cmd && (r_action == ACT_STOP) && (cmd_status == ST_OK);
    assign step_wr   = i_cmd.walk_step && slot_running;
    assign idx_last  = (r_idx == LAST_SLOT);
    assign emit_step = i_cmd.walk_step && expire && r_pend_valid;

    // The next slot is fetched while the current one retires.
    assign rd_en   = i_cmd.walk_start || (i_cmd.walk_step && !idx_last);
    assign rd_addr = i_cmd.walk_start ? '0 : r_idx + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (start_wr) begin
            r_mem[cmd_slot] <= start_word;
        end else if (step_wr) begin
            r_mem[r_idx] <= step_word;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= i_in_action;
            r_id       <= i_in_data[ID_W-1:0];
            r_period   <= i_in_data[ID_W+PERIOD_W-1:ID_W];
            r_periodic <= i_in_data[ID_W+PERIOD_W];
        end
        if (i_cmd.do_cmd) begin
            r_out_kind   <= KIND_STATUS;
            r_out_id     <= r_id;
            r_out_status <= cmd_status;
            r_out_last   <= 1'b1;
        end else if (emit_step || i_cmd.flush_emit) begin
            r_out_kind   <= KIND_EXPIRY;
            r_out_id     <= ID_W'(r_pend_id);
            r_out_status <= ST_OK;
            r_out_last   <= i_cmd.flush_emit;
        end
        if (i_cmd.walk_step && expire) begin
            r_pend_id <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_period <= '1;
            r_running    <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_period <= i_cfg_wr_data;
            end
            if (start_wr) begin
                r_running[cmd_slot] <= 1'b1;
            end else if (stop_clr) begin
                r_running[cmd_slot] <= 1'b0;
            end else if (step_wr && expire && !slot_per) begin
                r_running[r_idx] <= 1'b0;
            end
            if (i_cmd.walk_start) begin
                r_idx <= '0;
            end else if (i_cmd.walk_step && !idx_last) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.walk_start || i_cmd.flush_emit) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.walk_step && expire) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    assign o_stat.is_tick    = (r_action == ACT_TICK);
    assign o_stat.expire     = expire;
    assign o_stat.idx_last   = idx_last;
    assign o_stat.pend_valid = r_pend_valid;

    assign o_out_kind   = r_out_kind;
    assign o_out_id     = r_out_id;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start_wr && step_wr))
        else $error("slot memory written by a start and a tick step at once");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend_id <= LAST_SLOT))
        else $error("held expiry names a slot beyond the table");

endmodule

// File: hw/rtl/mtem_ctrl.sv
// Controller of the timer manager: sequences command execution and the
// slot walk of a tick, and owns the output valid flag. Depends on mtem_pkg.
module mtem_ctrl import mtem_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_CMD, S_SLOT, S_FLUSH} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   out_load;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMD;
                end
            end
            S_CMD: begin
                if (i_stat.is_tick) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_SLOT;
                end else if (out_free) begin
                    o_cmd.do_cmd = 1'b1;
                    out_load     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SLOT: begin
                // An expiry pushes the previously held one out; it waits for room.
                if (!(i_stat.expire && i_stat.pend_valid) || out_free) begin
                    o_cmd.walk_step = 1'b1;
                    out_load        = i_stat.expire && i_stat.pend_valid;
                    if (i_stat.idx_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.flush_emit = 1'b1;
                    out_load         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.pend_valid)
        else $error("expiry left behind at the end of a tick");

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before it was taken");

    a_last_slot_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.walk_step && i_stat.idx_last) |=> (r_state == S_FLUSH))
        else $error("walk did not end after the last slot");

endmodule

// File: hw/rtl/multi_timer_expiry_manager_core.sv
// Top level of the multi-timer expiry manager: stream ports, config port,
// controller and datapath. Depends on mtem_pkg, mtem_ctrl and mtem_datapath.
//
// A table of NUM_TIMERS countdown slots driven by start, stop and tick items.
// Start and stop each pass through a command state on the way back to idle,
// and their status result is loaded in that state, which is held while an
// earlier result still waits for the output.
// A tick walks the slot memory one slot per cycle, holding on a slot while an
// expiry waits for the output item to be taken, and then passes a flush state.
// Expiries leave in ascending slot order and the final one of a tick carries
// tlast; a tick with no expiry gives nothing.
// Every status result carries tlast. One item is worked on at a time; the
// output register lets the next item be accepted while a result waits.
module multi_timer_expiry_manager_core import mtem_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: timer_id [3:0], period_ticks [35:4], periodic [36], zero [39:37]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action [1:0]
    input  logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: timer_id_res [3:0], status [5:4], zero [7:6]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: kind [0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_wr_en,
    input  logic [PERIOD_W-1:0]   i_cfg_wr_data
);

    localparam int PAD_W = M_TDATA_W - ID_W - STATUS_W;

    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic                out_kind;
    logic [ID_W-1:0]     out_id;
    logic [STATUS_W-1:0] out_status;

    mtem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    mtem_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_data     (s_axis_tdata),
        .i_in_action   (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_kind    (out_kind),
        .o_out_id      (out_id),
        .o_out_status  (out_status),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_status, out_id};
    assign m_axis_tuser = out_kind;

endmodule

// File: verif/tb_multi_timer_expiry_manager_core.sv
// Self-checking testbench for multi_timer_expiry_manager_core: start, stop and tick items
// with random idling on both streams and a scoreboard that mirrors the timer table.
// Depends on mtem_pkg and the block's RTL.
module tb_multi_timer_expiry_manager_core import mtem_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 63;

    // Action code the block does not define; it must be answered as invalid.
    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     slot;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_timer_result;

    class timer_table_scoreboard;
        logic [PERIOD_W-1:0] max_period;
        logic [PERIOD_W-1:0] countdown[SLOTS];
        logic [PERIOD_W-1:0] reload[SLOTS];
        bit                  periodic_mode[SLOTS];
        bit                  armed[SLOTS];
        t_timer_result       pending[$];
        int                  errors;

        function new();
            max_period = '1;
            errors     = 0;
            foreach (armed[i]) begin
                countdown[i]     = '0;
                reload[i]        = '0;
                periodic_mode[i] = 1'b0;
                armed[i]         = 1'b0;
            end
        endfunction

        function void note_command(logic [ACTION_W-1:0] action, logic [ID_W-1:0] slot,
                                   logic [PERIOD_W-1:0] period, logic per);
            t_timer_result r;
            int n;
            int i;
            if (action == ACT_TICK) begin
                n = 0;
                for (i = 0; i < SLOTS; i++) begin
                    if (!armed[i]) continue;
                    if (countdown[i] <= 1) begin
                        r.kind   = KIND_EXPIRY;
                        r.slot   = ID_W'(i);
                        r.status = ST_OK;
                        r.last   = 1'b0;
                        pending.push_back(r);
                        n++;
                        if (periodic_mode[i]) begin
                            countdown[i] = reload[i];
                        end else begin
                            countdown[i] = '0;
                            armed[i]     = 1'b0;
                        end
                    end else begin
                        countdown[i] = countdown[i] - 1;
                    end
                end
                // Only the final expiry of a tick is marked as the end of the run.
                if (n > 0) pending[pending.size()-1].last = 1'b1;
                return;
            end
            r.kind = KIND_STATUS;
            r.slot = slot;
            r.last = 1'b1;
            if (action == ACT_START) begin
                if (period == 0 || period > max_period) begin
                    r.status = ST_INVALID;
                end else if (armed[slot]) begin
                    r.status = ST_BUSY;
                end else begin
                    countdown[slot]     = period;
                    reload[slot]        = period;
                    periodic_mode[slot] = per;
                    armed[slot]         = 1'b1;
                    r.status            = ST_OK;
                end
            end else if (action == ACT_STOP) begin
                if (!armed[slot]) begin
                    r.status = ST_BUSY;
                end else begin
                    armed[slot] = 1'b0;
                    r.status    = ST_OK;
                end
            end else begin
                r.status = ST_INVALID;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic kind, logic last);
            t_timer_result e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: kind %0d slot %0d status %0d last %0d",
                       kind, data[3:0], data[5:4], last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (data[3:0] !== e.slot) begin
                $error("timer_id_res: expected %0d, actual %0d", e.slot, data[3:0]);
                errors++;
            end
            if (data[5:4] !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, data[5:4]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [ACTION_W-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_wr_en;
    logic [PERIOD_W-1:0]  i_cfg_wr_data;

    bit no_idle = 1'b0;
    timer_table_scoreboard sb = new();

    multi_timer_expiry_manager_core #(
        .NUM_TIMERS (SLOTS),
        .TICK_WIDTH (PERIOD_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_command(logic [ACTION_W-1:0] action, logic [ID_W-1:0] slot,
                                logic [PERIOD_W-1:0] period, logic per);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= S_TDATA_W'({per, period, slot});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(action, slot, period, per);
    endtask

    task automatic send_random_command();
        logic [ACTION_W-1:0] action;
        logic [PERIOD_W-1:0] period;
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 40)      action = ACT_TICK;
        else if (r < 72) action = ACT_START;
        else if (r < 92) action = ACT_STOP;
        else             action = ACT_UNDEFINED;
        // Mostly short periods so that slots expire often; the rest probes the limits.
        p = $urandom_range(0, 99);
        if (p < 6)       period = '0;
        else if (p < 10) period = '1;
        else if (p < 14) period = sb.max_period;
        else if (p < 18) period = sb.max_period + 1;
        else if (p < 30) period = $urandom;
        else             period = $urandom_range(1, 8);
        send_command(action, ID_W'($urandom_range(0, SLOTS - 1)), period,
                     1'($urandom_range(0, 1)));
    endtask

    // A tick with no expiry gives no result, so the walk may still run after the queue empties.
    task automatic wait_until_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_period(logic [PERIOD_W-1:0] value);
        wait_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.max_period = value;
    endtask

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        end
    end

    initial begin
        logic [PERIOD_W-1:0] limits[4];
        int ph;
        int k;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_TICK;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(ACT_START, 4'd0, 32'd1, 1'b0);
        send_command(ACT_START, 4'd0, 32'd3, 1'b1);
        send_command(ACT_START, 4'd1, 32'd0, 1'b0);
        send_command(ACT_START, 4'd15, '1, 1'b1);
        send_command(ACT_STOP, 4'd3, 32'd0, 1'b0);
        send_command(ACT_UNDEFINED, 4'd7, $urandom, 1'b1);
        send_command(ACT_TICK, 4'd0, 32'd0, 1'b0);
        send_command(ACT_TICK, 4'd0, 32'd0, 1'b0);
        send_command(ACT_STOP, 4'd15, 32'd0, 1'b0);
        send_command(ACT_STOP, 4'd0, 32'd0, 1'b0);
        // Every slot expiring on the same tick.
        for (k = 0; k < SLOTS; k++) send_command(ACT_START, ID_W'(k), 32'd1, 1'b1);
        send_command(ACT_TICK, 4'd0, 32'd0, 1'b0);
        send_command(ACT_TICK, 4'd0, 32'd0, 1'b0);

        limits[0] = 32'd1;
        limits[1] = $urandom_range(2, 12);
        limits[2] = '1;
        limits[3] = $urandom_range(1, 32'hFFFF_FFFF);
        for (ph = 0; ph < 4; ph++) begin
            s_axis_tvalid <= 1'b0;
            write_max_period(limits[ph]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (k < 20);
                send_random_command();
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        wait_until_drained();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mtem_pkg.sv
hw/rtl/mtem_datapath.sv
hw/rtl/mtem_ctrl.sv
hw/rtl/multi_timer_expiry_manager_core.sv
verif/tb_multi_timer_expiry_manager_core.sv
